### hw/rtl/polar_to_cartesian_with_covariance_assert.svh
`ifndef POLAR_TO_CARTESIAN_WITH_COVARIANCE_ASSERT_SVH
`define POLAR_TO_CARTESIAN_WITH_COVARIANCE_ASSERT_SVH

// check that cond holds on every clock edge out of reset
`define P2C_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("p2c: invariant violated");

// check that trig is followed by resp after the delay given as n
`define P2C_ASSERT_DELAY(label, trig, n, resp) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> ##n (resp)) \
		else $error("p2c: latency violated");

// check that trig implies cond in the same cycle
`define P2C_ASSERT_IMPLIES(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("p2c: result out of range");

`endif

### hw/rtl/p2c_pkg.sv
package p2c_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_N = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
	localparam int CW = 34;
	localparam int ZW = 33;
	localparam int LATENCY = CORDIC_N + 6;

	typedef logic signed [CW-1:0] cval_t;
	typedef logic signed [ZW-1:0] zval_t;

	typedef struct packed {
		logic valid;
		logic flip;
	} cctl_t;

	typedef struct packed {
		logic [15:0] r;
		logic [11:0] sr;
		logic [15:0] sa;
	} meas_t;

	localparam cval_t GAIN_Q30 = 34'sd652032874;
	localparam zval_t HALF_PI_BA = 33'sd1073741824;
	localparam zval_t PI_BA = 33'sd2147483648;

	function automatic logic [29:0] atan_ba(input int i);
		logic [29:0] v;
		case (i)
			0: v = 30'd536870912;
			1: v = 30'd316933406;
			2: v = 30'd167458907;
			3: v = 30'd85004756;
			4: v = 30'd42667331;
			5: v = 30'd21354465;
			6: v = 30'd10679838;
			7: v = 30'd5340245;
			8: v = 30'd2670163;
			9: v = 30'd1335087;
			10: v = 30'd667544;
			11: v = 30'd333772;
			12: v = 30'd166886;
			13: v = 30'd83443;
			14: v = 30'd41722;
			15: v = 30'd20861;
			16: v = 30'd10430;
			17: v = 30'd5215;
			18: v = 30'd2608;
			19: v = 30'd1304;
			20: v = 30'd652;
			21: v = 30'd326;
			22: v = 30'd163;
			23: v = 30'd81;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

### hw/rtl/p2c_cordic.sv
module p2c_cordic import p2c_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cctl_t in_ctl,
	input  zval_t in_z,
	output cctl_t out_ctl,
	output cval_t out_c,
	output cval_t out_s
);

	cval_t x_s [0:CORDIC_N];
	cval_t y_s [0:CORDIC_N];
	zval_t z_s [0:CORDIC_N];
	cctl_t ctl_s [0:CORDIC_N];

	assign x_s[0] = GAIN_Q30;
	assign y_s[0] = '0;
	assign z_s[0] = in_z;
	assign ctl_s[0] = in_ctl;

	for (genvar i = 0; i < CORDIC_N; i++) begin : g_step
		localparam zval_t ATAN = zval_t'(atan_ba(i));
		cval_t nx, ny;
		zval_t nz;

		always_comb begin
			if (!z_s[i][ZW-1]) begin
				nx = x_s[i] - (y_s[i] >>> i);
				ny = y_s[i] + (x_s[i] >>> i);
				nz = z_s[i] - ATAN;
			end else begin
				nx = x_s[i] + (y_s[i] >>> i);
				ny = y_s[i] - (x_s[i] >>> i);
				nz = z_s[i] + ATAN;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			x_s[i+1] <= nx;
			y_s[i+1] <= ny;
			z_s[i+1] <= nz;
		end
	end

	assign out_ctl = ctl_s[CORDIC_N];
	assign out_c = ctl_s[CORDIC_N].flip ? -x_s[CORDIC_N] : x_s[CORDIC_N];
	assign out_s = ctl_s[CORDIC_N].flip ? -y_s[CORDIC_N] : y_s[CORDIC_N];

	logic unused_z;
	assign unused_z = ^z_s[CORDIC_N];

endmodule

### hw/rtl/polar_to_cartesian_with_covariance.sv
// Polar radar detection to Cartesian point with first-order covariance.
// Input: raise start with range_m, azimuth, range_dev and azimuth_dev; the
// beat is taken on any edge where start is high and busy is low. busy is
// always low, so a detection can enter on every clock cycle.
// Output: done pulses for one cycle with pos_x, pos_y, cov_xx, cov_xy and
// cov_yy; the receiver must take the beat in that cycle.
// Pipeline from the accepting edge to done: one angle fold stage, one CORDIC
// stage per step, then five stages of multiply, round and saturate.
// Throughput: one detection per cycle, set by the fully unrolled CORDIC and
// one multiplier bank per stage.
// Reset: arst_n clears all valid bits; beats in flight are dropped and done
// stays low until new beats drain through.
// The receiver cannot stall, so nothing holds the pipeline.
module polar_to_cartesian_with_covariance import p2c_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [15:0]        range_m,
	input  logic signed [15:0] azimuth,
	input  logic [11:0]        range_dev,
	input  logic [15:0]        azimuth_dev,
	output logic               done,
	output logic signed [16:0] pos_x,
	output logic signed [16:0] pos_y,
	output logic [31:0]        cov_xx,
	output logic signed [31:0] cov_xy,
	output logic [31:0]        cov_yy
);

	assign busy = 1'b0;

	// angle fold
	zval_t z_in, z_s0;
	cctl_t ctl_s0;
	logic flip_in;
	zval_t z_fold;

	assign z_in = zval_t'($signed({azimuth, 16'b0}));

	always_comb begin
		flip_in = 1'b0;
		z_fold = z_in;
		if (z_in > HALF_PI_BA) begin
			z_fold = z_in - PI_BA;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI_BA) begin
			z_fold = z_in + PI_BA;
			flip_in = 1'b1;
		end
	end

	meas_t meas_s [0:CORDIC_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0 <= '{valid: start & ~busy, flip: flip_in};
		end
	end

	always_ff @(posedge clk) begin
		z_s0 <= z_fold;
		meas_s[0] <= '{r: range_m, sr: range_dev, sa: azimuth_dev};
	end

	for (genvar k = 0; k < CORDIC_N; k++) begin : g_line
		always_ff @(posedge clk) begin
			meas_s[k+1] <= meas_s[k];
		end
	end

	cctl_t ctl_c;
	cval_t cos_c, sin_c;

	p2c_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ctl (ctl_s0),
		.in_z   (z_s0),
		.out_ctl(ctl_c),
		.out_c  (cos_c),
		.out_s  (sin_c)
	);

	meas_t m_c;
	assign m_c = meas_s[CORDIC_N];

	// stage 1: range times sine and cosine, sine and cosine products, sr squared, r*sa
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [50:0] rc_s1, rs_s1;
	logic signed [67:0] cc_s1, ss_s1, csp_s1;
	logic [29:0] p_s1;
	logic [31:0] rsa_s1;

	always_ff @(posedge clk) begin
		rc_s1 <= $signed({1'b0, m_c.r}) * cos_c;
		rs_s1 <= $signed({1'b0, m_c.r}) * sin_c;
		cc_s1 <= cos_c * cos_c;
		ss_s1 <= sin_c * sin_c;
		csp_s1 <= cos_c * sin_c;
		p_s1 <= {24'(m_c.sr) * 24'(m_c.sr), 6'b0};
		rsa_s1 <= 32'(m_c.r) * 32'(m_c.sa);
	end

	// stage 2: round, clamp position, square r*sa
	logic signed [20:0] px_r, py_r;
	logic signed [16:0] px_c, py_c;
	logic signed [16:0] px_s2, py_s2, px_s3, py_s3, px_s4, py_s4;
	logic signed [25:0] c2_s2, s2_s2, cs_s2, c2_s3, s2_s3, cs_s3;
	logic [29:0] p_s2, p_s3;
	logic [63:0] rsa2_s2;
	logic signed [67:0] c2_r, s2_r, cs_r;

	assign px_r = 21'((rc_s1 + (51'sd1 <<< 29)) >>> 30);
	assign py_r = 21'((rs_s1 + (51'sd1 <<< 29)) >>> 30);
	assign c2_r = (cc_s1 + (68'sd1 <<< 35)) >>> 36;
	assign s2_r = (ss_s1 + (68'sd1 <<< 35)) >>> 36;
	assign cs_r = (csp_s1 + (68'sd1 <<< 35)) >>> 36;

	always_comb begin
		if (px_r > 21'sd65535) begin
			px_c = 17'sd65535;
		end else if (px_r < -21'sd65535) begin
			px_c = -17'sd65535;
		end else begin
			px_c = 17'(px_r);
		end
		if (py_r > 21'sd65535) begin
			py_c = 17'sd65535;
		end else if (py_r < -21'sd65535) begin
			py_c = -17'sd65535;
		end else begin
			py_c = 17'(py_r);
		end
	end

	always_ff @(posedge clk) begin
		px_s2 <= px_c;
		py_s2 <= py_c;
		c2_s2 <= 26'(c2_r);
		s2_s2 <= 26'(s2_r);
		cs_s2 <= 26'(cs_r);
		p_s2 <= p_s1;
		rsa2_s2 <= rsa_s1 * rsa_s1;
	end

	// stage 3: round the squared term, form P + Q
	logic [38:0] q_s3;
	logic [39:0] pq_s3;
	logic [38:0] q_r;

	assign q_r = 39'(rsa2_s2 >> 26) + 39'(rsa2_s2[25]);

	always_ff @(posedge clk) begin
		q_s3 <= q_r;
		pq_s3 <= 40'(p_s2) + 40'(q_r);
		px_s3 <= px_s2;
		py_s3 <= py_s2;
		c2_s3 <= c2_s2;
		s2_s3 <= s2_s2;
		cs_s3 <= cs_s2;
		p_s3 <= p_s2;
	end

	// stage 4: covariance products
	logic signed [67:0] a_s4, b_s4, d_s4, e_s4, f_s4;

	always_ff @(posedge clk) begin
		a_s4 <= c2_s3 * $signed({1'b0, p_s3});
		b_s4 <= s2_s3 * $signed({1'b0, q_s3});
		d_s4 <= s2_s3 * $signed({1'b0, p_s3});
		e_s4 <= c2_s3 * $signed({1'b0, q_s3});
		f_s4 <= cs_s3 * $signed({1'b0, pq_s3});
		px_s4 <= px_s3;
		py_s4 <= py_s3;
	end

	// stage 5: round and saturate
	logic signed [67:0] xx_r, yy_r, xy_r;
	logic [31:0] xx_c, yy_c;
	logic signed [31:0] xy_c;

	assign xx_r = (a_s4 + b_s4 + (68'sd1 <<< 35)) >>> 36;
	assign yy_r = (d_s4 + e_s4 + (68'sd1 <<< 35)) >>> 36;
	assign xy_r = (f_s4 + (68'sd1 <<< 35)) >>> 36;

	always_comb begin
		if (xx_r < 68'sd0) begin
			xx_c = '0;
		end else if (xx_r > 68'sd4294967295) begin
			xx_c = '1;
		end else begin
			xx_c = 32'(xx_r);
		end
		if (yy_r < 68'sd0) begin
			yy_c = '0;
		end else if (yy_r > 68'sd4294967295) begin
			yy_c = '1;
		end else begin
			yy_c = 32'(yy_r);
		end
		if (xy_r < -68'sd2147483648) begin
			xy_c = 32'sh80000000;
		end else if (xy_r > 68'sd2147483647) begin
			xy_c = 32'sh7fffffff;
		end else begin
			xy_c = 32'(xy_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1 <= ctl_c.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			done <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		pos_x <= px_s4;
		pos_y <= py_s4;
		cov_xx <= xx_c;
		cov_yy <= yy_c;
		cov_xy <= xy_c;
	end

`include "polar_to_cartesian_with_covariance_assert.svh"

	`P2C_ASSERT_ALWAYS(a_never_busy, busy == 1'b0)
	`P2C_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
	`P2C_ASSERT_IMPLIES(a_pos_range, done, pos_x != -17'sd65536 && pos_y != -17'sd65536)

endmodule
